// ----- hdl/hps_pkg.sv -----
// Package for the host:port splitter.
// Holds the parser mode codes, action codes, byte constants and the result struct.
// No dependencies.
package hps_pkg;

    // Default saturation length of the byte position counter.
    localparam int unsigned HPS_MAX_LEN = 4096;

    // Width of the reported error position.
    localparam int unsigned ERR_POS_W = 12;

    // Parser modes.
    localparam logic [2:0] MODE_START   = 3'd0;
    localparam logic [2:0] MODE_HOST    = 3'd1;
    localparam logic [2:0] MODE_PORT    = 3'd2;
    localparam logic [2:0] MODE_BRACKET = 3'd3;
    localparam logic [2:0] MODE_SEP     = 3'd4;
    localparam logic [2:0] MODE_FAILED  = 3'd5;

    // Byte routing actions.
    localparam logic [1:0] ACT_DROP    = 2'd0;
    localparam logic [1:0] ACT_HOST    = 2'd1;
    localparam logic [1:0] ACT_PORT    = 2'd2;
    localparam logic [1:0] ACT_RESTART = 2'd3;

    // Special bytes.
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_DASH     = 8'h2D;

    // Verdict for one byte.
    typedef struct packed {
        logic [1:0]           action;
        logic                 failed;
        logic [ERR_POS_W-1:0] error_pos;
    } hps_result_t;

    // ASCII letters and digits only.
    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

// ----- hdl/hps_parser.sv -----
// Parser state and per-byte decision logic of the host:port splitter.
// Depends on hps_pkg.
module hps_parser
    import hps_pkg::*;
#(
    parameter int unsigned MAX_LEN = HPS_MAX_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  ch,
    input  logic        last,
    output hps_result_t result
);

    localparam int unsigned IDX_W = $clog2(MAX_LEN);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LEN - 1);

    logic [2:0]       mode_reg, mode_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic             port_ne_reg, port_ne_next;
    logic [IDX_W-1:0] fail_reg, fail_next;

    logic [1:0]             act;
    logic [2:0]             mode_dec;
    logic                   fail_now;
    logic [IDX_W-1:0]       epos;
    logic [IDX_W+ERR_POS_W-1:0] epos_ext;

    // Mode transition and byte routing.
    always_comb begin
        act          = ACT_DROP;
        mode_dec     = mode_reg;
        port_ne_next = port_ne_reg;
        case (mode_reg)
            MODE_START: begin
                if (ch == CH_LBRACKET) begin
                    mode_dec = MODE_BRACKET;
                end else if (is_alnum(ch)) begin
                    mode_dec = MODE_HOST;
                    act      = ACT_HOST;
                end else if (ch == CH_STAR) begin
                    mode_dec = MODE_SEP;
                    act      = ACT_HOST;
                end else begin
                    mode_dec = MODE_FAILED;
                end
            end
            MODE_SEP: begin
                mode_dec = (ch == CH_COLON) ? MODE_PORT : MODE_FAILED;
            end
            MODE_HOST: begin
                if (ch == CH_COLON) begin
                    mode_dec = MODE_PORT;
                end else if (is_alnum(ch) || ch == CH_DOT || ch == CH_DASH) begin
                    act = ACT_HOST;
                end else begin
                    mode_dec = MODE_FAILED;
                end
            end
            MODE_BRACKET: begin
                if (ch == CH_RBRACKET) begin
                    mode_dec = MODE_SEP;
                end else if (is_alnum(ch) || ch == CH_COLON || ch == CH_DOT ||
                             ch == CH_DASH) begin
                    act = ACT_HOST;
                end else begin
                    mode_dec = MODE_FAILED;
                end
            end
            MODE_PORT: begin
                if (is_alnum(ch)) begin
                    act          = ACT_PORT;
                    port_ne_next = 1'b1;
                end else if (ch == CH_STAR) begin
                    act          = ACT_RESTART;
                    port_ne_next = 1'b1;
                end else begin
                    mode_dec = MODE_FAILED;
                end
            end
            default: begin
                mode_dec = MODE_FAILED;
            end
        endcase
    end

    // Failure position capture and the verdict for this byte.
    always_comb begin
        fail_next = fail_reg;
        if (mode_reg < MODE_FAILED && mode_dec == MODE_FAILED) begin
            fail_next = index_reg;
        end
        fail_now = (mode_dec == MODE_FAILED);
        epos     = fail_now ? fail_next : '0;
        if (last && !fail_now) begin
            if (mode_dec == MODE_BRACKET || (mode_dec == MODE_PORT && !port_ne_next)) begin
                fail_now = 1'b1;
                epos     = index_reg;
            end
        end
    end

    assign epos_ext         = {{ERR_POS_W{1'b0}}, epos};
    assign result.action    = act;
    assign result.failed    = fail_now;
    assign result.error_pos = epos_ext[ERR_POS_W-1:0];

    // Saturating byte position.
    assign index_next = (index_reg < IDX_MAX) ? index_reg + 1'b1 : index_reg;

    // State update; the last byte returns everything to its reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_START;
            index_reg   <= '0;
            port_ne_reg <= 1'b0;
            fail_reg    <= '0;
        end else if (step) begin
            if (last) begin
                mode_reg    <= MODE_START;
                index_reg   <= '0;
                port_ne_reg <= 1'b0;
                fail_reg    <= '0;
            end else begin
                mode_reg    <= mode_dec;
                index_reg   <= index_next;
                port_ne_reg <= port_ne_next;
                fail_reg    <= fail_next;
            end
        end
    end

endmodule

// ----- hdl/host_port_splitter_core.sv -----
// Top level of the host:port splitter: input register, parser, result register.
// Depends on hps_pkg and hps_parser.

// Takes a host:port or [host]:port string one byte per transfer, with tlast on
// the final byte, and returns one result per byte: where the byte goes, the
// running failure flag and the position of the first bad byte; the result for
// the last byte carries tlast and the final verdict. The block sustains one
// byte per clock cycle while the result side is not stalled; a byte passes
// through the input register and then the result register, and the only loop
// is the parser mode and position update. Both registers keep accepting
// while the downstream side is stalled until they are full.
module host_port_splitter_core
    import hps_pkg::*;
#(
    parameter int unsigned MAX_LEN = HPS_MAX_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input bytes.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // last
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] action, [2] failed, [14:3] error_pos, [15] zero
    output logic        m_axis_tlast    // final_res
);

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       last_reg;

    logic        out_valid_reg;
    hps_result_t res_reg;
    logic        final_reg;

    hps_result_t res;
    logic        step;

    // The parser advances when a held byte can move into the result register.
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            ch_reg   <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    hps_parser #(
        .MAX_LEN(MAX_LEN)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .ch      (ch_reg),
        .last    (last_reg),
        .result  (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg   <= res;
            final_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg.error_pos, res_reg.failed, res_reg.action};
    assign m_axis_tlast  = final_reg;

endmodule

// ----- hdl/hps_checker.sv -----
// Port-level checks for the host:port splitter, bound to the top level.
// Depends on host_port_splitter_core.
module hps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
    else $error("stalled result changed");

    // Error position is zero while the string is still good.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[14:3] == 12'd0)
    else $error("error position set without failure");

    // Padding bit stays clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !m_axis_tdata[15])
    else $error("padding bit set");

    // An offered input transfer is taken while the result side is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused with an empty result register");

    // No result comes out of reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind host_port_splitter_core hps_checker u_hps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for host_port_splitter_core: streams host:port strings in and
// checks every result against a cycle-free predictor of the parser.
// Depends on hps_pkg and the RTL of host_port_splitter_core.
`timescale 1ns / 1ps

module testbench;
    import hps_pkg::*;

    localparam int unsigned SPLIT_MAX_LEN = HPS_MAX_LEN;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_ITEMS  = 650;
    localparam int unsigned DRAIN_CYCLES  = 8;

    // One result of the splitter, as the predictor sees it.
    typedef struct packed {
        logic [1:0]           action;
        logic                 fin;
        logic                 failed;
        logic [ERR_POS_W-1:0] epos;
    } verdict_t;

    // One row of the directed part: a byte and, where obvious, its result.
    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
        logic       typed;
        verdict_t   want;
    } stim_row_t;

    localparam int NUM_ROWS = 23;

    // Short strings that hit every parser mode, action and verdict path.
    stim_row_t directed_rows [NUM_ROWS] = '{
        // Plain host with dot and dash, one-digit port.
        '{"a",         1'b0, 1'b1, '{ACT_HOST,    1'b0, 1'b0, 12'd0}},
        '{CH_DOT,      1'b0, 1'b0, '0},
        '{CH_DASH,     1'b0, 1'b0, '0},
        '{CH_COLON,    1'b0, 1'b0, '0},
        '{"1",         1'b1, 1'b1, '{ACT_PORT,    1'b1, 1'b0, 12'd0}},
        // Bracketed host holding a colon, port restarted by a star.
        '{CH_LBRACKET, 1'b0, 1'b1, '{ACT_DROP,    1'b0, 1'b0, 12'd0}},
        '{CH_COLON,    1'b0, 1'b0, '0},
        '{CH_RBRACKET, 1'b0, 1'b0, '0},
        '{CH_COLON,    1'b0, 1'b0, '0},
        '{CH_STAR,     1'b1, 1'b1, '{ACT_RESTART, 1'b1, 1'b0, 12'd0}},
        // Star host, then a bad byte in the port.
        '{CH_STAR,     1'b0, 1'b0, '0},
        '{CH_COLON,    1'b0, 1'b0, '0},
        '{"Z",         1'b0, 1'b0, '0},
        '{"!",         1'b1, 1'b1, '{ACT_DROP,    1'b1, 1'b1, 12'd3}},
        // Empty port after the colon.
        '{"h",         1'b0, 1'b0, '0},
        '{CH_COLON,    1'b1, 1'b1, '{ACT_DROP,    1'b1, 1'b1, 12'd1}},
        // Bracket never closed.
        '{CH_LBRACKET, 1'b0, 1'b0, '0},
        '{"x",         1'b1, 1'b1, '{ACT_HOST,    1'b1, 1'b1, 12'd1}},
        // Bad host byte, then a byte that is ignored.
        '{"z",         1'b0, 1'b0, '0},
        '{"?",         1'b0, 1'b1, '{ACT_DROP,    1'b0, 1'b1, 12'd1}},
        '{"A",         1'b1, 1'b1, '{ACT_DROP,    1'b1, 1'b1, 12'd1}},
        // Extreme byte values as whole strings.
        '{8'hFF,       1'b1, 1'b1, '{ACT_DROP,    1'b1, 1'b1, 12'd0}},
        '{8'h00,       1'b1, 1'b1, '{ACT_DROP,    1'b1, 1'b1, 12'd0}}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Predictor state.
    logic [2:0]  cur_mode;
    int unsigned cur_pos;
    logic        cur_port_seen;
    int unsigned cur_fail_pos;

    verdict_t    pending_verdicts[$];
    logic [7:0]  text_bytes[$];

    int unsigned burst_left = 0;
    int unsigned rx_left = 0;
    int unsigned rx_mode = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned strings_sent = 0;
    int unsigned rejected_strings = 0;

    host_port_splitter_core #(
        .MAX_LEN(SPLIT_MAX_LEN)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // Clock with an 8 ns period.
    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic is_letter_or_digit(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic void clear_parser();
        cur_mode = MODE_START;
        cur_pos = 0;
        cur_port_seen = 1'b0;
        cur_fail_pos = 0;
    endfunction

    // Advances the parser by one byte and returns the result that byte must produce.
    function automatic verdict_t split_byte(input logic [7:0] ch, input logic lst);
        verdict_t    v;
        logic [2:0]  nxt;
        int unsigned at;
        at = cur_pos;
        nxt = cur_mode;
        v.action = ACT_DROP;
        case (cur_mode)
            MODE_START: begin
                if (ch == CH_LBRACKET) begin
                    nxt = MODE_BRACKET;
                end else if (is_letter_or_digit(ch)) begin
                    nxt = MODE_HOST;
                    v.action = ACT_HOST;
                end else if (ch == CH_STAR) begin
                    nxt = MODE_SEP;
                    v.action = ACT_HOST;
                end else begin
                    nxt = MODE_FAILED;
                end
            end
            MODE_SEP: begin
                nxt = (ch == CH_COLON) ? MODE_PORT : MODE_FAILED;
            end
            MODE_HOST: begin
                if (ch == CH_COLON) begin
                    nxt = MODE_PORT;
                end else if (is_letter_or_digit(ch) || ch == CH_DOT || ch == CH_DASH) begin
                    v.action = ACT_HOST;
                end else begin
                    nxt = MODE_FAILED;
                end
            end
            MODE_BRACKET: begin
                if (ch == CH_RBRACKET) begin
                    nxt = MODE_SEP;
                end else if (is_letter_or_digit(ch) || ch == CH_COLON || ch == CH_DOT ||
                             ch == CH_DASH) begin
                    v.action = ACT_HOST;
                end else begin
                    nxt = MODE_FAILED;
                end
            end
            MODE_PORT: begin
                if (is_letter_or_digit(ch)) begin
                    v.action = ACT_PORT;
                    cur_port_seen = 1'b1;
                end else if (ch == CH_STAR) begin
                    v.action = ACT_RESTART;
                    cur_port_seen = 1'b1;
                end else begin
                    nxt = MODE_FAILED;
                end
            end
            default: begin
                nxt = MODE_FAILED;
            end
        endcase

        // The first bad byte fixes the error position for the rest of the string.
        if (cur_mode < MODE_FAILED && nxt == MODE_FAILED) begin
            cur_fail_pos = at;
        end
        cur_mode = nxt;
        v.failed = (cur_mode == MODE_FAILED);
        v.epos = v.failed ? cur_fail_pos[ERR_POS_W-1:0] : '0;

        // The last byte also rejects an open bracket or an empty port.
        if (lst && !v.failed &&
            (cur_mode == MODE_BRACKET || (cur_mode == MODE_PORT && !cur_port_seen))) begin
            v.failed = 1'b1;
            v.epos = at[ERR_POS_W-1:0];
        end
        if (cur_pos < SPLIT_MAX_LEN - 1) begin
            cur_pos++;
        end
        v.fin = lst;
        if (lst) begin
            clear_parser();
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d, result %0d: %0s got %0d, expected %0d",
                 cycle_count, results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Adds one byte to the end of the string being built.
    function automatic void put_byte(input logic [7:0] b);
        text_bytes = {text_bytes, b};
    endfunction

    // Random byte classes for the string generator.
    function automatic logic [7:0] rand_alnum();
        case ($urandom_range(2))
            0: return 8'($urandom_range("9", "0"));
            1: return 8'($urandom_range("Z", "A"));
            default: return 8'($urandom_range("z", "a"));
        endcase
    endfunction

    function automatic logic [7:0] rand_host_char(input logic bracketed);
        case ($urandom_range(9))
            0: return CH_DOT;
            1: return CH_DASH;
            2: return bracketed ? CH_COLON : rand_alnum();
            default: return rand_alnum();
        endcase
    endfunction

    function automatic logic [7:0] rand_port_char();
        return ($urandom_range(6) == 0) ? CH_STAR : rand_alnum();
    endfunction

    // Either any byte, an extreme or special byte, or one lying just outside a character class.
    function automatic logic [7:0] rand_odd_byte();
        case ($urandom_range(13))
            0: return 8'h2F;
            1: return 8'h40;
            2: return 8'h60;
            3: return 8'h7B;
            4: return 8'h00;
            5: return 8'hFF;
            6: return CH_LBRACKET;
            7: return CH_RBRACKET;
            8: return CH_COLON;
            9: return CH_STAR;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void append_port();
        int unsigned n;
        n = $urandom_range(4);
        put_byte(CH_COLON);
        repeat (n) put_byte(rand_port_char());
    endfunction

    // Builds one string: mostly well formed, some corrupted, truncated or pure noise.
    function automatic void compose_text();
        int unsigned kind;
        int unsigned n;
        int unsigned idx;
        text_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 40) begin
            put_byte(rand_alnum());
            n = $urandom_range(6);
            repeat (n) put_byte(rand_host_char(1'b0));
            append_port();
        end else if (kind < 65) begin
            put_byte(CH_LBRACKET);
            n = $urandom_range(6);
            repeat (n) put_byte(rand_host_char(1'b1));
            put_byte(CH_RBRACKET);
            append_port();
        end else if (kind < 80) begin
            put_byte(CH_STAR);
            append_port();
        end else begin
            n = $urandom_range(6, 1);
            repeat (n) put_byte(rand_odd_byte());
        end

        if (kind < 80 && $urandom_range(4) == 0) begin
            idx = $urandom_range(text_bytes.size() - 1);
            text_bytes[idx] = rand_odd_byte();
        end
        if (kind < 80 && $urandom_range(9) == 0) begin
            n = $urandom_range(text_bytes.size() - 1, 1);
            while (text_bytes.size() > n) void'(text_bytes.pop_back());
        end
    endfunction

    // Sends one byte in bursts with random gaps; called and returns at a falling edge.
    task automatic send_byte(input logic [7:0] ch, input logic lst,
                             input logic use_typed, input verdict_t typed_want);
        int unsigned gap;
        verdict_t    predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(24, 1);
        end
        burst_left--;
        s_axis_tdata = ch;
        s_axis_tlast = lst;
        s_axis_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = split_byte(ch, lst);
        if (use_typed) begin
            predicted = typed_want;
        end
        pending_verdicts = {pending_verdicts, predicted};
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text();
        foreach (text_bytes[i]) begin
            send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, '0);
        end
        strings_sent++;
    endtask

    // Holds the input idle until every expected result has come back.
    task automatic wait_for_results();
        s_axis_tvalid = 1'b0;
        while (pending_verdicts.size() != 0) @(negedge aclk);
        burst_left = 0;
    endtask

    // Receiver readiness: always ready, coin toss, or mostly stalled, in stretches.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(2);
            rx_left = $urandom_range(80, 16);
        end
        rx_left--;
        case (rx_mode)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = 1'($urandom_range(1));
            default: m_axis_tready = ($urandom_range(7) == 0);
        endcase
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin : check_result
            verdict_t want;
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", m_axis_tdata, -1);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[1:0] != want.action)
                    report_mismatch("action", m_axis_tdata[1:0], want.action);
                if (m_axis_tlast != want.fin)
                    report_mismatch("final flag", m_axis_tlast, want.fin);
                if (m_axis_tdata[2] != want.failed)
                    report_mismatch("failed", m_axis_tdata[2], want.failed);
                if (m_axis_tdata[14:3] != want.epos)
                    report_mismatch("error_pos", m_axis_tdata[14:3], want.epos);
                if (want.fin && want.failed)
                    rejected_strings++;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_verdicts.size());
            $display("testbench failed");
            $finish;
        end
    end

    // Main sequence: reset, directed rows, random strings, drain.
    initial begin
        clear_parser();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_byte(directed_rows[r].ch, directed_rows[r].lst,
                      directed_rows[r].typed, directed_rows[r].want);
            if (directed_rows[r].lst)
                strings_sent++;
        end
        wait_for_results();

        while (items_sent < NUM_ROWS + RANDOM_ITEMS) begin
            compose_text();
            send_text();
        end

        s_axis_tvalid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in %0d strings and checked %0d results;", items_sent,
                 strings_sent, results_seen);
        $display("%0d strings ended with a rejecting verdict.", rejected_strings);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
